/* sv/pie_pkg.sv */
`default_nettype none
package pie_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;

    // Q16.16 value width and divider dividend width (|a| shifted up by 16)
    localparam int Q_W   = 32;
    localparam int DIV_W = 48;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_SATURATED = 3'd4;

    // Operator stack codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [Q_W-1:0]   divisor;
        logic             neg;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic             neg;
    } t_div_rsp;

endpackage
`default_nettype wire

/* sv/parenthesized_infix_evaluator.sv */
`default_nettype none
// Sequencing: '(', an operator or a value character is taken in S_IDLE; ')' with + or - runs
//   S_EXEC and S_WB, with * S_EXEC, S_MUL (registered 32x32 product) and S_WB, with / S_EXEC,
//   S_DIV (24 radix-4 divider steps) and S_WB. The last character then passes S_END and S_OUT,
//   waiting in S_OUT while an earlier result is still held; no new character is taken until S_IDLE.
// Reset (synchronous, i_rst_n low) empties both stacks, clears the status and the output
//   valid; stack memories are not cleared, only entries below the stack tops are read.
module parenthesized_infix_evaluator
    import pie_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  wire logic        i_s_tlast,   // last
    // result channel
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata    // [31:0] value, [34:32] status, [39:35] zero
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int RW = 49;   // wide result before clamping

    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    localparam logic signed [RW-1:0] RES_MAX = 49'sd2147483647;
    localparam logic signed [RW-1:0] RES_MIN = -49'sd2147483648;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // Stack memories, read registered every cycle at the current tops
    logic signed [Q_W-1:0] r_vmem [STACK_DEPTH];
    logic [1:0]            r_omem [STACK_DEPTH];

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_vtop, n_vtop;
    logic [CW-1:0]         r_otop, n_otop;
    logic [2:0]            r_err, n_err;
    logic                  r_last, n_last;
    logic signed [RW-1:0]  r_res, n_res;
    logic signed [63:0]    r_prod, n_prod;
    logic                  r_out_valid, n_out_valid;
    logic [34:0]           r_out_data, n_out_data;

    logic signed [Q_W-1:0] r_rd_a;
    logic signed [Q_W-1:0] r_rd_b;
    logic [1:0]            r_rd_op;

    logic                  w_acc;
    logic [7:0]            w_ch;
    logic                  w_is_op;
    logic [1:0]            w_op;
    logic                  w_fatal;
    logic signed [8:0]     w_cdig;
    logic signed [Q_W-1:0] w_cval;
    logic [CW-1:0]         w_vm1;
    logic [CW-1:0]         w_vm2;
    logic [CW-1:0]         w_om1;
    logic                  w_vwe;
    logic [AW-1:0]         w_vwaddr;
    logic signed [Q_W-1:0] w_vwdata;
    logic                  w_owe;
    logic [Q_W-1:0]        w_amag;
    logic [Q_W-1:0]        w_bmag;
    logic                  w_hi;
    logic                  w_lo;
    logic signed [Q_W-1:0] w_clamp;
    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;

    assign w_acc   = i_s_tvalid & o_s_tready;
    assign w_ch    = i_s_tdata;
    assign w_is_op = (w_ch == CH_PLUS) || (w_ch == CH_MINUS) ||
                     (w_ch == CH_STAR) || (w_ch == CH_SLASH);
    assign w_fatal = (r_err != ST_OK) && (r_err != ST_SATURATED);

    // Any other character is a digit value: (code - '0') in Q16.16
    assign w_cdig = $signed({1'b0, w_ch}) - $signed({1'b0, CH_ZERO});
    assign w_cval = {{7{w_cdig[8]}}, w_cdig, 16'b0};

    assign w_vm1 = r_vtop - CW'(1);
    assign w_vm2 = r_vtop - CW'(2);
    assign w_om1 = r_otop - CW'(1);

    always_comb begin
        unique case (w_ch)
            CH_PLUS:  w_op = OP_ADD;
            CH_MINUS: w_op = OP_SUB;
            CH_STAR:  w_op = OP_MUL;
            default:  w_op = OP_DIV;
        endcase
    end

    // Magnitudes for the divider; -2^31 maps to 2^31 unsigned
    assign w_amag = r_rd_a[Q_W-1] ? Q_W'(-r_rd_a) : Q_W'(r_rd_a);
    assign w_bmag = r_rd_b[Q_W-1] ? Q_W'(-r_rd_b) : Q_W'(r_rd_b);

    // Saturate the wide result to Q16.16
    assign w_hi    = (r_res > RES_MAX);
    assign w_lo    = (r_res < RES_MIN);
    assign w_clamp = w_hi ? Q_W'(RES_MAX) : (w_lo ? Q_W'(RES_MIN) : Q_W'(r_res));

    always_comb begin
        n_state     = r_state;
        n_vtop      = r_vtop;
        n_otop      = r_otop;
        n_err       = r_err;
        n_last      = r_last;
        n_res       = r_res;
        n_prod      = r_prod;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        w_vwe       = 1'b0;
        w_vwaddr    = r_vtop[AW-1:0];
        w_vwdata    = w_cval;
        w_owe       = 1'b0;
        w_div_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_last  = i_s_tlast;
                    n_state = i_s_tlast ? S_END : S_IDLE;
                    // after a fatal error, drop characters until the last one
                    if (!w_fatal) begin
                        if (w_is_op) begin
                            if (r_otop >= DEPTH_C) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                w_owe  = 1'b1;
                                n_otop = r_otop + CW'(1);
                            end
                        end else if (w_ch == CH_OPEN) begin
                            n_state = i_s_tlast ? S_END : S_IDLE;
                        end else if (w_ch == CH_CLOSE) begin
                            if (r_otop == '0 || r_vtop < CW'(2)) begin
                                n_err = ST_UNDERFLOW;
                            end else begin
                                // operands are read at this edge, used in S_EXEC
                                n_state = S_EXEC;
                            end
                        end else begin
                            if (r_vtop >= DEPTH_C) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                w_vwe  = 1'b1;
                                n_vtop = r_vtop + CW'(1);
                            end
                        end
                    end
                end
            end
            S_EXEC: begin
                n_otop = w_om1;
                case (r_rd_op)
                    OP_ADD: begin
                        n_res   = RW'(r_rd_a) + RW'(r_rd_b);
                        n_state = S_WB;
                    end
                    OP_SUB: begin
                        n_res   = RW'(r_rd_a) - RW'(r_rd_b);
                        n_state = S_WB;
                    end
                    OP_MUL: begin
                        n_prod  = 64'(r_rd_a) * 64'(r_rd_b);
                        n_state = S_MUL;
                    end
                    default: begin
                        if (r_rd_b == '0) begin
                            n_err   = ST_DIVZERO;
                            n_state = r_last ? S_END : S_IDLE;
                        end else begin
                            w_div_req.start    = 1'b1;
                            w_div_req.dividend = {w_amag, 16'b0};
                            w_div_req.divisor  = w_bmag;
                            w_div_req.neg      = r_rd_a[Q_W-1] ^ r_rd_b[Q_W-1];
                            n_state            = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                // arithmetic shift rounds toward minus infinity
                n_res   = RW'(r_prod >>> 16);
                n_state = S_WB;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_res   = w_div_rsp.neg ? -$signed({1'b0, w_div_rsp.quot})
                                            :  $signed({1'b0, w_div_rsp.quot});
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // pop two, push one: the result lands where the left operand was
                if ((w_hi || w_lo) && r_err == ST_OK) begin
                    n_err = ST_SATURATED;
                end
                w_vwe    = 1'b1;
                w_vwaddr = w_vm2[AW-1:0];
                w_vwdata = w_clamp;
                n_vtop   = w_vm1;
                n_state  = r_last ? S_END : S_IDLE;
            end
            S_END: begin
                // let the top-of-stack read settle
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    if (w_fatal) begin
                        n_out_data = {r_err, {Q_W{1'b0}}};
                    end else if (r_vtop == '0) begin
                        n_out_data = {ST_UNDERFLOW, {Q_W{1'b0}}};
                    end else begin
                        n_out_data = {r_err, r_rd_b};
                    end
                    n_vtop  = '0;
                    n_otop  = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vtop      <= '0;
            r_otop      <= '0;
            r_err       <= ST_OK;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vtop      <= n_vtop;
            r_otop      <= n_otop;
            r_err       <= n_err;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_vmem[w_vwaddr] <= w_vwdata;
        end
        r_rd_a <= r_vmem[w_vm2[AW-1:0]];
        r_rd_b <= r_vmem[w_vm1[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_owe) begin
            r_omem[r_otop[AW-1:0]] <= w_op;
        end
        r_rd_op <= r_omem[w_om1[AW-1:0]];
    end

    pie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_data};

endmodule
`default_nettype wire

/* sv/pie_div.sv */
`default_nettype none
// Unsigned restoring divider, two quotient bits per cycle.
module pie_div
    import pie_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [Q_W-1:0]   r_rem;
    logic [DIV_W-1:0] r_q;
    logic [Q_W-1:0]   r_div;
    logic             r_neg;

    logic [Q_W:0]   w_t1;
    logic [Q_W:0]   w_t2;
    logic [Q_W-1:0] w_rem1;
    logic [Q_W-1:0] w_rem2;
    logic           w_ge1;
    logic           w_ge2;

    // Two shift-and-subtract steps per cycle
    always_comb begin
        w_t1   = {r_rem, r_q[DIV_W-1]};
        w_ge1  = (w_t1 >= {1'b0, r_div});
        w_rem1 = w_ge1 ? Q_W'(w_t1 - {1'b0, r_div}) : w_t1[Q_W-1:0];
        w_t2   = {w_rem1, r_q[DIV_W-2]};
        w_ge2  = (w_t2 >= {1'b0, r_div});
        w_rem2 = w_ge2 ? Q_W'(w_t2 - {1'b0, r_div}) : w_t2[Q_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_div <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= w_rem2;
            r_q   <= {r_q[DIV_W-3:0], w_ge1, w_ge2};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.neg  = r_neg;

endmodule
`default_nettype wire

/* sv/pie_checker.sv */
`default_nettype none
module pie_checker
    import pie_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Drop any pending result on reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[34:32] <= ST_SATURATED && o_m_tdata[39:35] == 5'b0)
        else $error("bad status code or padding");

    // Fatal statuses carry a zero value
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[34:32] == ST_OVERFLOW || o_m_tdata[34:32] == ST_UNDERFLOW ||
                       o_m_tdata[34:32] == ST_DIVZERO) |-> o_m_tdata[31:0] == 32'b0)
        else $error("nonzero value with fatal status");

endmodule

bind parenthesized_infix_evaluator pie_checker u_pie_checker (.*);
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
    import pie_pkg::*;

    localparam int  DEPTH      = DEFAULT_STACK_DEPTH;
    localparam int  RAND_ITEMS = 600;
    localparam int  CALM_ITEMS = 540;    // no idling on either side past this point
    localparam int  HOLD_LEN   = 400;    // long result-side hold-off
    localparam int  DRAIN_LEN  = 40;     // settle time after the last result
    localparam int  WATCHDOG   = 2000;   // cycles with no handshake before giving up

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // Markers for the expression builder work stack; characters are >= 0.
    localparam int SYM_EXPR = -1;
    localparam int SYM_OP   = -2;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } expr_result_t;

    typedef struct packed {
        logic [7:0]   code;
        logic         last;
        logic         typed;
        expr_result_t want;
    } char_row_t;

    localparam expr_result_t NO_RES = '{32'h0, ST_OK};

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] char_code
    logic        i_s_tlast  = 1'b0;    // last
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;            // [31:0] value, [34:32] status, [39:35] zero

    always #5 i_clk = ~i_clk;

    parenthesized_infix_evaluator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    expr_result_t expr_results [$];    // results still owed by the block, oldest first
    logic [7:0]   expr_chars [$];      // characters of the expression being built
    int           fail_count = 0;
    int           rand_items = 0;
    bit           idle_on    = 1'b1;
    bit           stall_req  = 1'b0;

    // Evaluator shadow: value stack, operator stack and sticky status.
    logic signed [31:0] val_stack [DEPTH];
    logic [1:0]         op_stack [DEPTH];
    int unsigned        val_top  = 0;
    int unsigned        op_top   = 0;
    logic [2:0]         eval_err = ST_OK;

    // Directed characters. Only results that are obvious at a glance are typed in;
    // the rest fall through to the shadow evaluator.
    char_row_t directed_rows [24] = '{
        // single value on an empty block
        '{CH_ZERO + 8'd7, 1'b1, 1'b1, '{32'h0007_0000, ST_OK}},
        // close with nothing on either stack
        '{CH_CLOSE,       1'b1, 1'b1, '{32'h0, ST_UNDERFLOW}},
        // open paren alone leaves the value stack empty
        '{CH_OPEN,        1'b1, 1'b1, '{32'h0, ST_UNDERFLOW}},
        // largest code squared saturates high
        '{8'hFF,          1'b0, 1'b0, NO_RES},
        '{CH_STAR,        1'b0, 1'b0, NO_RES},
        '{8'hFF,          1'b0, 1'b0, NO_RES},
        '{CH_CLOSE,       1'b1, 1'b1, '{32'h7FFF_FFFF, ST_SATURATED}},
        // saturation followed by a fatal underflow: the fatal code wins
        '{8'hFF,          1'b0, 1'b0, NO_RES},
        '{CH_STAR,        1'b0, 1'b0, NO_RES},
        '{8'hFF,          1'b0, 1'b0, NO_RES},
        '{CH_CLOSE,       1'b0, 1'b0, NO_RES},
        '{CH_CLOSE,       1'b1, 1'b1, '{32'h0, ST_UNDERFLOW}},
        // divide by zero
        '{CH_ZERO + 8'd9, 1'b0, 1'b0, NO_RES},
        '{CH_SLASH,       1'b0, 1'b0, NO_RES},
        '{CH_ZERO,        1'b0, 1'b0, NO_RES},
        '{CH_CLOSE,       1'b1, 1'b1, '{32'h0, ST_DIVZERO}},
        // smallest code is a negative value
        '{8'h00,          1'b1, 1'b1, '{32'hFFD0_0000, ST_OK}},
        // 2 + (3 - 9), brackets left out since they are ignored
        '{CH_ZERO + 8'd2, 1'b0, 1'b0, NO_RES},
        '{CH_PLUS,        1'b0, 1'b0, NO_RES},
        '{CH_ZERO + 8'd3, 1'b0, 1'b0, NO_RES},
        '{CH_MINUS,       1'b0, 1'b0, NO_RES},
        '{CH_ZERO + 8'd9, 1'b0, 1'b0, NO_RES},
        '{CH_CLOSE,       1'b0, 1'b0, NO_RES},
        '{CH_CLOSE,       1'b1, 1'b0, NO_RES}
    };

    // ------------------------------------------------------------------
    // Shadow evaluator
    // ------------------------------------------------------------------
    function automatic bit err_fatal();
        return eval_err != ST_OK && eval_err != ST_SATURATED;
    endfunction

    function automatic void raise_fatal(input logic [2:0] code);
        if (!err_fatal()) eval_err = code;
    endfunction

    function automatic void push_val(input logic signed [31:0] v);
        if (val_top >= DEPTH) begin
            raise_fatal(ST_OVERFLOW);
        end else begin
            val_stack[val_top] = v;
            val_top++;
        end
    endfunction

    // Advance the shadow by one character; return 1 with the result on a last character.
    function automatic bit eval_char(input logic [7:0] c, input bit last,
                                     output expr_result_t res);
        longint lhs, rhs, acc;
        bit     div_zero;
        res = NO_RES;
        div_zero = 1'b0;
        if (!err_fatal()) begin
            if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
                if (op_top >= DEPTH) begin
                    raise_fatal(ST_OVERFLOW);
                end else begin
                    op_stack[op_top] = (c == CH_PLUS)  ? OP_ADD :
                                       (c == CH_MINUS) ? OP_SUB :
                                       (c == CH_STAR)  ? OP_MUL : OP_DIV;
                    op_top++;
                end
            end else if (c == CH_OPEN) begin
                // brackets carry no information in a fully parenthesized stream
            end else if (c == CH_CLOSE) begin
                if (op_top == 0 || val_top < 2) begin
                    raise_fatal(ST_UNDERFLOW);
                end else begin
                    op_top--;
                    lhs = val_stack[val_top - 2];
                    rhs = val_stack[val_top - 1];
                    val_top -= 2;
                    case (op_stack[op_top])
                        OP_ADD: acc = lhs + rhs;
                        OP_SUB: acc = lhs - rhs;
                        OP_MUL: begin
                            // drop 16 fraction bits, rounding toward minus infinity
                            acc = lhs * rhs;
                            if (acc >= 0) acc = acc / 65536;
                            else          acc = -((-acc + 65535) / 65536);
                        end
                        default: begin
                            if (rhs == 0) begin
                                raise_fatal(ST_DIVZERO);
                                div_zero = 1'b1;
                            end else begin
                                acc = (lhs * 65536) / rhs;  // truncates toward zero
                            end
                        end
                    endcase
                    if (!div_zero) begin
                        if (acc > Q_MAX || acc < Q_MIN) begin
                            if (eval_err == ST_OK) eval_err = ST_SATURATED;
                            acc = (acc > Q_MAX) ? Q_MAX : Q_MIN;
                        end
                        push_val(acc[31:0]);
                    end
                end
            end else begin
                push_val(32'((longint'(c) - longint'(CH_ZERO)) * 65536));
            end
        end
        if (!last) return 1'b0;
        if (!err_fatal()) begin
            if (val_top == 0) eval_err = ST_UNDERFLOW;
            else              res.value = val_stack[val_top - 1];
        end
        res.status = eval_err;
        val_top  = 0;
        op_top   = 0;
        eval_err = ST_OK;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Expression builder
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_leaf(input bit wild);
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 99);
        if (wild && r < 50) begin
            c = (r < 40) ? 8'hFF : 8'h00;
        end else if (r < 75) begin
            c = CH_ZERO + 8'($urandom_range(0, 9));
        end else if (r < 85) begin
            c = r[0] ? 8'hFF : 8'h00;
        end else begin
            // any other code is a value too; keep clear of operators and brackets
            c = 8'($urandom_range(0, 255));
            while (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                   c == CH_OPEN || c == CH_CLOSE)
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Fill expr_chars with a fully parenthesized expression of up to 'nodes' operators.
    function automatic void build_expr(input int nodes, input bit wild);
        int work [$];
        int sym;
        expr_chars.delete();
        work.push_back(SYM_EXPR);
        while (work.size() > 0) begin
            sym = work.pop_back();
            if (sym == SYM_EXPR) begin
                if (nodes > 0 && $urandom_range(0, 2) != 0) begin
                    nodes--;
                    expr_chars.push_back(CH_OPEN);
                    // pushed in reverse: left operand pops first
                    work.push_back(int'(CH_CLOSE));
                    work.push_back(SYM_EXPR);
                    work.push_back(SYM_OP);
                    work.push_back(SYM_EXPR);
                end else begin
                    expr_chars.push_back(pick_leaf(wild));
                end
            end else if (sym == SYM_OP) begin
                case ($urandom_range(0, 3))
                    0:       expr_chars.push_back(CH_PLUS);
                    1:       expr_chars.push_back(CH_MINUS);
                    2:       expr_chars.push_back(CH_STAR);
                    default: expr_chars.push_back(CH_SLASH);
                endcase
            end else begin
                expr_chars.push_back(8'(sym));
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one character, hold it until taken, then record what the block owes.
    task automatic send_char(input logic [7:0] c, input bit last,
                             input bit typed, input expr_result_t want);
        expr_result_t res;
        if (idle_on && $urandom_range(0, 99) < 12) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        if (eval_char(c, last, res))
            expr_results.push_back(typed ? want : res);
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_chars.size(); i++) begin
            send_char(expr_chars[i], i == expr_chars.size() - 1, 1'b0, NO_RES);
            rand_items++;
            idle_on = (rand_items < CALM_ITEMS);
        end
    endtask

    initial begin : stimulus
        int  kind;
        int  run_len;
        int  pos;
        bit  val_run_done;
        bit  op_run_done;
        val_run_done = 1'b0;
        op_run_done  = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed rows.
        foreach (directed_rows[i])
            send_char(directed_rows[i].code, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        // Hold the result side off while short expressions keep coming, so the block
        // backs up and has to stall its request side.
        stall_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            expr_chars.delete();
            expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            send_expr();
        end

        while (rand_items < RAND_ITEMS) begin
            if (!val_run_done && rand_items >= 200) begin
                // fill the value stack from one entry short of its depth up to past it
                val_run_done = 1'b1;
                run_len = $urandom_range(DEPTH - 1, DEPTH + 3);
                expr_chars.delete();
                repeat (run_len) expr_chars.push_back(pick_leaf(1'b0));
                send_expr();
            end else if (!op_run_done && rand_items >= 350) begin
                // fill the operator stack from one entry short of its depth up to past it
                op_run_done = 1'b1;
                run_len = $urandom_range(DEPTH - 1, DEPTH + 3);
                expr_chars.delete();
                repeat (run_len) expr_chars.push_back(CH_PLUS);
                expr_chars.push_back(CH_ZERO + 8'd5);
                send_expr();
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 65) begin
                    build_expr($urandom_range(0, 6), 1'b0);
                end else if (kind < 75) begin
                    // well-formed expression with large or negative operands
                    build_expr($urandom_range(1, 6), 1'b1);
                end else if (kind < 87) begin
                    // broken expression: drop one character or insert a random one
                    build_expr($urandom_range(1, 6), 1'b0);
                    pos = $urandom_range(0, expr_chars.size() - 1);
                    if ($urandom_range(0, 1)) expr_chars.delete(pos);
                    else expr_chars.insert(pos, 8'($urandom_range(0, 255)));
                    if (expr_chars.size() == 0) expr_chars.push_back(CH_CLOSE);
                end else begin
                    // noise: raw codes with last scattered through the run
                    run_len = $urandom_range(1, 8);
                    for (int i = 0; i < run_len; i++) begin
                        send_char(8'($urandom_range(0, 255)),
                                  (i == run_len - 1) || ($urandom_range(0, 3) == 0),
                                  1'b0, NO_RES);
                        rand_items++;
                        idle_on = (rand_items < CALM_ITEMS);
                    end
                    expr_chars.delete();
                end
                if (expr_chars.size() != 0) send_expr();
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain: wait for every owed result, then let the pipeline settle.
        while (expr_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (expr_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, expr_results.size());
        end
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: check each accepted result, then pick the next tready
    // ------------------------------------------------------------------
    initial begin : result_sink
        expr_result_t want;
        logic [31:0]  got_val;
        logic [2:0]   got_st;
        int           hold_left;
        int           gap_left;
        hold_left = 0;
        gap_left  = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                got_val = o_m_tdata[31:0];
                got_st  = o_m_tdata[34:32];
                if (expr_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result value %h status %0d",
                             $time, got_val, got_st);
                end else begin
                    want = expr_results.pop_front();
                    if (got_val !== want.value) begin
                        fail_count++;
                        $display("%0t: value mismatch expected %h actual %h",
                                 $time, want.value, got_val);
                    end
                    if (got_st !== want.status) begin
                        fail_count++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, got_st);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_req) begin
                stall_req = 1'b0;
                hold_left = HOLD_LEN - 1;
                i_m_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 12) begin
                gap_left = $urandom_range(0, 9);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up after a long stretch with no handshake on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
`default_nettype wire
